// ----- hdl/fdq_pkg.sv -----
// Shared types and constants of the fetch delay queue.
`timescale 1ns / 1ps
package fdq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int MaxForwardDefault = 8;
  localparam int CmdFifoDepth      = 2;
  localparam int ResFifoDepth      = 2;

  localparam int TagW      = 16;
  localparam int AddrW     = 64;
  localparam int SizeW     = 8;
  localparam int DelayW    = 8;
  localparam int LimitInW  = 4;
  localparam int CmdLimitW = 6;
  localparam int CountW    = 5;

  localparam logic [DelayW-1:0] PenaltyReset = 8'd20;

  typedef enum logic {
    ModeInstr = 1'b0,
    ModeTick  = 1'b1
  } fdq_mode_e;

  typedef enum logic [1:0] {
    KindUpdate  = 2'd0,
    KindForward = 2'd1,
    KindStatus  = 2'd2
  } fdq_kind_e;

  typedef struct packed {
    fdq_mode_e              mode;
    logic [TagW-1:0]        tag;
    logic [DelayW-1:0]      delay;
    logic [CmdLimitW-1:0]   limit;
    logic                   has_upd;
    logic [AddrW-1:0]       upd_addr;
    logic                   upd_taken;
    logic                   upd_mis;
  } fdq_cmd_t;

  typedef struct packed {
    fdq_kind_e              kind;
    logic [TagW-1:0]        fwd_tag;
    logic [AddrW-1:0]       branch_addr;
    logic                   branch_taken;
    logic                   mispredicted;
    logic [CountW-1:0]      queue_count;
    logic                   overflow;
    logic                   last;
  } fdq_res_t;

endpackage

// ----- hdl/fdq_fifo.sv -----
// Small register FIFO used between the front and back parts and at the result side.
`timescale 1ns / 1ps
module fdq_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hdl/fdq_front.sv -----
// Front part: accepts items, checks the pending prediction and builds back-end commands.
`timescale 1ns / 1ps
module fdq_front import fdq_pkg::*; #(
  parameter int MAX_FORWARD = MaxForwardDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                mode_i,
  input  logic [TagW-1:0]     instr_tag_i,
  input  logic [AddrW-1:0]    instr_addr_i,
  input  logic                addr_valid_i,
  input  logic [SizeW-1:0]    instr_size_i,
  input  logic                is_branch_i,
  input  logic                predicted_taken_i,
  input  logic [LimitInW-1:0] accept_limit_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [DelayW-1:0]   cfg_data_i,
  output logic                cmd_push_o,
  output fdq_cmd_t            cmd_o,
  input  logic                cmd_full_i
);

  logic [DelayW-1:0] penalty_q, penalty_d;
  logic [AddrW-1:0]  prev_addr_q, prev_addr_d;
  logic              prev_ok_q, prev_ok_d;
  logic [SizeW-1:0]  prev_size_q, prev_size_d;
  logic              pend_valid_q, pend_valid_d;
  logic              pend_taken_q, pend_taken_d;
  logic              accept, is_instr, check, taken, mis;
  logic [AddrW-1:0]  next_addr;

  assign full        = cmd_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = push && !cmd_full_i;
  assign is_instr    = (fdq_mode_e'(mode_i) == ModeInstr);
  assign next_addr   = prev_addr_q + AddrW'(prev_size_q);
  assign taken       = (instr_addr_i != next_addr);
  assign mis         = (taken != pend_taken_q);
  assign check       = is_instr && pend_valid_q && addr_valid_i && prev_ok_q;

  always_comb begin
    cmd_o.mode      = fdq_mode_e'(mode_i);
    cmd_o.tag       = instr_tag_i;
    cmd_o.delay     = (check && mis) ? penalty_q : '0;
    cmd_o.limit     = (CmdLimitW'(accept_limit_i) > CmdLimitW'(MAX_FORWARD)) ?
                      CmdLimitW'(MAX_FORWARD) : CmdLimitW'(accept_limit_i);
    cmd_o.has_upd   = check;
    cmd_o.upd_addr  = prev_addr_q;
    cmd_o.upd_taken = taken;
    cmd_o.upd_mis   = mis;
  end

  assign cmd_push_o = accept;

  always_comb begin
    penalty_d    = penalty_q;
    prev_addr_d  = prev_addr_q;
    prev_ok_d    = prev_ok_q;
    prev_size_d  = prev_size_q;
    pend_valid_d = pend_valid_q;
    pend_taken_d = pend_taken_q;
    if (cfg_valid_i) begin
      penalty_d = cfg_data_i;
    end
    if (accept && is_instr) begin
      pend_valid_d = is_branch_i && addr_valid_i;
      pend_taken_d = is_branch_i && addr_valid_i && predicted_taken_i;
      prev_addr_d  = addr_valid_i ? instr_addr_i : '0;
      prev_ok_d    = addr_valid_i;
      prev_size_d  = instr_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      penalty_q    <= PenaltyReset;
      prev_addr_q  <= '0;
      prev_ok_q    <= 1'b0;
      prev_size_q  <= '0;
      pend_valid_q <= 1'b0;
      pend_taken_q <= 1'b0;
    end else begin
      penalty_q    <= penalty_d;
      prev_addr_q  <= prev_addr_d;
      prev_ok_q    <= prev_ok_d;
      prev_size_q  <= prev_size_d;
      pend_valid_q <= pend_valid_d;
      pend_taken_q <= pend_taken_d;
    end
  end

endmodule

// ----- hdl/fdq_back.sv -----
// Back part: delay queue memory and the sequencer that enqueues, ticks, forwards and reports updates and status.
`timescale 1ns / 1ps
module fdq_back import fdq_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int MAX_FORWARD = MaxForwardDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fdq_cmd_t cmd_i,
  input  logic     cmd_empty_i,
  output logic     cmd_pop_o,
  output logic     res_push_o,
  output fdq_res_t res_o,
  input  logic     res_full_i
);

  localparam int PtrW  = $clog2(QUEUE_DEPTH);
  localparam int OccW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LimW  = $clog2(MAX_FORWARD + 1);
  localparam int EntW  = DelayW + TagW;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StUpd    = 8'b0000_0010,
    StEnq    = 8'b0000_0100,
    StTickRd = 8'b0000_1000,
    StTick   = 8'b0001_0000,
    StFwdRd  = 8'b0010_0000,
    StFwd    = 8'b0100_0000,
    StStatus = 8'b1000_0000
  } fdq_state_e;

  fdq_state_e       state_q, state_d;
  fdq_cmd_t         cmd_q, cmd_d;
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [LimW-1:0]  sent_q, sent_d;
  logic             ovf_q, ovf_d;

  logic [EntW-1:0]  mem_q [QUEUE_DEPTH];
  logic [EntW-1:0]  rd_q;
  logic             mem_we;
  logic [PtrW-1:0]  mem_waddr;
  logic [EntW-1:0]  mem_wdata;
  logic [DelayW-1:0] rd_delay;
  logic [TagW-1:0]  rd_tag;
  logic             can_fwd;

  assign rd_delay = rd_q[EntW-1:TagW];
  assign rd_tag   = rd_q[TagW-1:0];
  assign can_fwd  = (occ_q != '0) && (rd_delay == '0) &&
                    (CmdLimitW'(sent_q) < cmd_q.limit);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    sent_d     = sent_q;
    ovf_d      = ovf_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = tail_q;
    mem_wdata  = {cmd_q.delay, cmd_q.tag};
    res_push_o = 1'b0;
    res_o      = '0;
    res_o.kind = KindStatus;
    unique case (state_q)
      StIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          ovf_d     = 1'b0;
          sent_d    = '0;
          if (cmd_i.mode == ModeTick) begin
            state_d = StTickRd;
          end else if (cmd_i.has_upd) begin
            state_d = StUpd;
          end else begin
            state_d = StEnq;
          end
        end
      end
      StUpd: begin
        res_o.kind         = KindUpdate;
        res_o.branch_addr  = cmd_q.upd_addr;
        res_o.branch_taken = cmd_q.upd_taken;
        res_o.mispredicted = cmd_q.upd_mis;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = StEnq;
        end
      end
      StEnq: begin
        if (occ_q == OccW'(QUEUE_DEPTH)) begin
          ovf_d = 1'b1;
        end else begin
          mem_we = 1'b1;
          tail_d = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          occ_d  = occ_q + 1'b1;
        end
        state_d = StFwdRd;
      end
      StTickRd: begin
        state_d = StTick;
      end
      StTick: begin
        if ((occ_q != '0) && (rd_delay != '0)) begin
          mem_we    = 1'b1;
          mem_waddr = head_q;
          mem_wdata = {rd_delay - 1'b1, rd_tag};
        end
        state_d = StFwdRd;
      end
      StFwdRd: begin
        state_d = StFwd;
      end
      StFwd: begin
        if (can_fwd) begin
          res_o.kind    = KindForward;
          res_o.fwd_tag = rd_tag;
          if (!res_full_i) begin
            res_push_o = 1'b1;
            head_d  = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            occ_d   = occ_q - 1'b1;
            sent_d  = sent_q + 1'b1;
            state_d = StFwdRd;
          end
        end else begin
          state_d = StStatus;
        end
      end
      StStatus: begin
        res_o.kind        = KindStatus;
        res_o.queue_count = CountW'(occ_q);
        res_o.overflow    = ovf_q;
        res_o.last        = 1'b1;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      sent_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      sent_q  <= sent_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[head_q];
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(QUEUE_DEPTH))
    else $error("Delay queue occupancy exceeds its depth.");

  a_fwd_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == KindForward) |-> (occ_q != '0 && rd_delay == '0))
    else $error("An item was forwarded while its delay had not run out.");

  a_fwd_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == KindForward) |-> (CmdLimitW'(sent_q) < cmd_q.limit))
    else $error("More items were forwarded than the next stage accepts.");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_o.last == (res_o.kind == KindStatus)))
    else $error("The last flag does not match the status result.");

  a_status_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == KindStatus) |=> (state_q == StIdle))
    else $error("The sequencer did not return to idle after the status result.");

endmodule

// ----- hdl/fetch_delay_queue_mispredict.sv -----
// Top level of the fetch delay queue with branch mispredict penalty.
// The front part takes one item per cycle while its two-entry command queue has room and
// resolves the pending branch prediction as the item enters. The back part then works
// through one item at a time: an instruction passes an optional predictor update, the
// enqueue and the forward checks, and a tick counts down the head entry's delay before
// the forward checks; both end with a status result. The back sequencer waits for the
// registered read of the head entry of the delay queue memory before each check.
// Results pass through a two-entry result queue, so the back part keeps working while
// a result waits to be popped.
`timescale 1ns / 1ps
module fetch_delay_queue_mispredict import fdq_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int MAX_FORWARD = MaxForwardDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                mode_i,
  input  logic [TagW-1:0]     instr_tag_i,
  input  logic [AddrW-1:0]    instr_addr_i,
  input  logic                addr_valid_i,
  input  logic [SizeW-1:0]    instr_size_i,
  input  logic                is_branch_i,
  input  logic                predicted_taken_i,
  input  logic [LimitInW-1:0] accept_limit_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [DelayW-1:0]   cfg_data_i,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          kind_o,
  output logic [TagW-1:0]     fwd_tag_o,
  output logic [AddrW-1:0]    branch_addr_o,
  output logic                branch_taken_o,
  output logic                mispredicted_o,
  output logic [CountW-1:0]   queue_count_o,
  output logic                overflow_o,
  output logic                last_o
);

  fdq_cmd_t cmd_in, cmd_out;
  fdq_res_t res_in, res_out;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic     res_push, res_full;

  fdq_front #(
    .MAX_FORWARD(MAX_FORWARD)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .instr_tag_i      (instr_tag_i),
    .instr_addr_i     (instr_addr_i),
    .addr_valid_i     (addr_valid_i),
    .instr_size_i     (instr_size_i),
    .is_branch_i      (is_branch_i),
    .predicted_taken_i(predicted_taken_i),
    .accept_limit_i   (accept_limit_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in),
    .cmd_full_i       (cmd_full)
  );

  fdq_fifo #(
    .Width($bits(fdq_cmd_t)),
    .Depth(CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_out),
    .empty_o(cmd_empty)
  );

  fdq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_FORWARD(MAX_FORWARD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_out),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  fdq_fifo #(
    .Width($bits(fdq_res_t)),
    .Depth(ResFifoDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_out),
    .empty_o(empty)
  );

  assign kind_o         = res_out.kind;
  assign fwd_tag_o      = res_out.fwd_tag;
  assign branch_addr_o  = res_out.branch_addr;
  assign branch_taken_o = res_out.branch_taken;
  assign mispredicted_o = res_out.mispredicted;
  assign queue_count_o  = res_out.queue_count;
  assign overflow_o     = res_out.overflow;
  assign last_o         = res_out.last;

endmodule
